// File: hdl/fpfr_pkg.sv
// shared types and constants of the firmware page frame receiver
`timescale 1ns / 1ps
`default_nettype none

package fpfr_pkg;

   // result kinds
   typedef enum logic [3:0] {
      KIND_WRONG_INDEX = 4'd0,
      KIND_ECHO        = 4'd1,
      KIND_PAGE_DONE   = 4'd2,
      KIND_PAGE_WORD   = 4'd3,
      KIND_WRITE_OK    = 4'd4,
      KIND_WRITE_ERROR = 4'd5,
      KIND_RESET_ACK   = 4'd6,
      KIND_ERASE       = 4'd7,
      KIND_JUMP        = 4'd8,
      KIND_REFUSED     = 4'd9
   } kind_type;

   // input word codes
   localparam logic CMD_FRAME      = 1'b0;
   localparam logic CMD_WRITE_DONE = 1'b1;

   // upper three id bits select host frames, data frames or ignored ids
   localparam logic [2:0] ID_CLASS_HOST = 3'd0;
   localparam logic [2:0] ID_CLASS_DATA = 3'd1;

   localparam logic [31:0] ADDR_RESET = 32'h0804_0000;

   // csr map, register index is paddr[4:2]
   localparam int          REG_IDX_W      = 3;
   localparam int          CSR_ADDR_W     = 5;
   localparam logic [2:0]  REG_ENTER      = 3'd0;
   localparam logic [2:0]  REG_ADDRESS    = 3'd1;
   localparam logic [2:0]  REG_RESET      = 3'd2;
   localparam logic [2:0]  REG_JUMP       = 3'd3;
   localparam logic [2:0]  REG_ECHO       = 3'd4;

   localparam logic [7:0]  ENTER_ID_RESET   = 8'd16;
   localparam logic [7:0]  ADDRESS_ID_RESET = 8'd32;
   localparam logic [7:0]  RESET_ID_RESET   = 8'd48;
   localparam logic [7:0]  JUMP_ID_RESET    = 8'd144;
   localparam logic        ECHO_RESET       = 1'b1;

   typedef struct packed {
      logic [7:0] enter_cmd_id;
      logic [7:0] address_cmd_id;
      logic [7:0] reset_cmd_id;
      logic [7:0] jump_cmd_id;
      logic       echo_enable;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic execute;
      logic load_done;
      logic rd_en;
      logic load_word;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
      logic page_end;
      logic word_last;
   } dp_status_type;

endpackage

`default_nettype wire

// File: hdl/fpfr_if.sv
// word channels of the firmware page frame receiver
`timescale 1ns / 1ps
`default_nettype none

interface fpfr_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [10:0] frame_id;
   logic [63:0] payload;
   logic        write_ok;

   modport source (output valid, cmd, frame_id, payload, write_ok, input ready);
   modport sink (input valid, cmd, frame_id, payload, write_ok, output ready);
endinterface

interface fpfr_rsp_if;
   logic                valid;
   logic                ready;
   fpfr_pkg::kind_type  kind;
   logic [7:0]          exp_index;
   logic [7:0]          rcv_index;
   logic [15:0]         page_count;
   logic [15:0]         byte_sum;
   logic [31:0]         address;
   logic [63:0]         word;
   logic                last;

   modport source (output valid, kind, exp_index, rcv_index, page_count,
                   byte_sum, address, word, last, input ready);
   modport sink (input valid, kind, exp_index, rcv_index, page_count,
                 byte_sum, address, word, last, output ready);
endinterface

`default_nettype wire

// File: hdl/fpfr_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module fpfr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  wire logic                                    clock,
   input  wire logic                                    we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                        wdata,
   input  wire logic                                    re,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                        rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: hdl/fpfr_csr.sv
// configuration registers behind the apb port
`timescale 1ns / 1ps
`default_nettype none

module fpfr_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [fpfr_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                     pwdata,
   output logic      [31:0]                     prdata,
   output logic                                 pready,
   output fpfr_pkg::cfg_type                    cfg
);

   logic [7:0] enter_id_ff, enter_id_in;
   logic [7:0] address_id_ff, address_id_in;
   logic [7:0] reset_id_ff, reset_id_in;
   logic [7:0] jump_id_ff, jump_id_in;
   logic       echo_ff, echo_in;
   logic       wr_en;
   logic [fpfr_pkg::REG_IDX_W-1:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[fpfr_pkg::CSR_ADDR_W-1:2];

   always_comb begin
      enter_id_in   = enter_id_ff;
      address_id_in = address_id_ff;
      reset_id_in   = reset_id_ff;
      jump_id_in    = jump_id_ff;
      echo_in       = echo_ff;
      if (wr_en) begin
         unique case (reg_idx)
            fpfr_pkg::REG_ENTER:   enter_id_in   = pwdata[7:0];
            fpfr_pkg::REG_ADDRESS: address_id_in = pwdata[7:0];
            fpfr_pkg::REG_RESET:   reset_id_in   = pwdata[7:0];
            fpfr_pkg::REG_JUMP:    jump_id_in    = pwdata[7:0];
            fpfr_pkg::REG_ECHO:    echo_in       = pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enter_id_ff   <= fpfr_pkg::ENTER_ID_RESET;
         address_id_ff <= fpfr_pkg::ADDRESS_ID_RESET;
         reset_id_ff   <= fpfr_pkg::RESET_ID_RESET;
         jump_id_ff    <= fpfr_pkg::JUMP_ID_RESET;
         echo_ff       <= fpfr_pkg::ECHO_RESET;
      end else begin
         enter_id_ff   <= enter_id_in;
         address_id_ff <= address_id_in;
         reset_id_ff   <= reset_id_in;
         jump_id_ff    <= jump_id_in;
         echo_ff       <= echo_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         fpfr_pkg::REG_ENTER:   prdata = {24'd0, enter_id_ff};
         fpfr_pkg::REG_ADDRESS: prdata = {24'd0, address_id_ff};
         fpfr_pkg::REG_RESET:   prdata = {24'd0, reset_id_ff};
         fpfr_pkg::REG_JUMP:    prdata = {24'd0, jump_id_ff};
         fpfr_pkg::REG_ECHO:    prdata = {31'd0, echo_ff};
         default:               prdata = 32'd0;
      endcase
   end

   assign cfg.enter_cmd_id   = enter_id_ff;
   assign cfg.address_cmd_id = address_id_ff;
   assign cfg.reset_cmd_id   = reset_id_ff;
   assign cfg.jump_cmd_id    = jump_id_ff;
   assign cfg.echo_enable    = echo_ff;

endmodule

`default_nettype wire

// File: hdl/fpfr_ctrl.sv
// controller sequencing accept, execute, page report and page readout
`timescale 1ns / 1ps
`default_nettype none

module fpfr_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire fpfr_pkg::dp_status_type status,
   output fpfr_pkg::dp_cmd_type         cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_DONE,
      S_READ,
      S_WORD
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      cmd           = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (status.out_free) begin
               cmd.execute = 1'b1;
               state_in    = status.page_end ? S_DONE : S_IDLE;
            end
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.load_done = 1'b1;
               state_in      = S_READ;
            end
         end
         S_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = S_WORD;
         end
         S_WORD: begin
            if (status.out_free) begin
               cmd.load_word = 1'b1;
               state_in      = status.word_last ? S_IDLE : S_READ;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   ap_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_EXEC)
      else $error("accepted word not followed by execute");

   ap_read_then_word: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |=> state_ff == S_WORD && !req_ready)
      else $error("page read not followed by word load");

   ap_done_starts_read: assert property (@(posedge clock) disable iff (reset)
      cmd.load_done |=> cmd.rd_en)
      else $error("page done not followed by readout");
`endif

endmodule

`default_nettype wire

// File: hdl/fpfr_dp.sv
// datapath: loader state, page memory, output register
`timescale 1ns / 1ps
`default_nettype none

module fpfr_dp #(
   parameter int PAGE_WORDS = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire fpfr_pkg::dp_cmd_type    cmd,
   output fpfr_pkg::dp_status_type      status,
   input  wire fpfr_pkg::cfg_type       cfg,
   input  wire logic                    req_cmd,
   input  wire logic [10:0]             req_frame_id,
   input  wire logic [63:0]             req_payload,
   input  wire logic                    req_write_ok,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output fpfr_pkg::kind_type           rsp_kind,
   output logic [7:0]                   rsp_exp_index,
   output logic [7:0]                   rsp_rcv_index,
   output logic [15:0]                  rsp_page_count,
   output logic [15:0]                  rsp_byte_sum,
   output logic [31:0]                  rsp_address,
   output logic [63:0]                  rsp_word,
   output logic                         rsp_last
);

   localparam int                IDX_W     = (PAGE_WORDS > 1) ? $clog2(PAGE_WORDS) : 1;
   localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(PAGE_WORDS - 1);
   localparam logic [31:0]       ADDR_STEP = 32'(PAGE_WORDS * 8);

   // captured input word
   logic        hold_cmd_ff;
   logic [10:0] hold_id_ff;
   logic [63:0] hold_payload_ff;
   logic        hold_wok_ff;

   // loader state
   logic [IDX_W-1:0] next_index_ff, next_index_in;
   logic [15:0]      running_sum_ff, running_sum_in;
   logic [15:0]      pages_done_ff, pages_done_in;
   logic [31:0]      start_address_ff, start_address_in;
   logic [31:0]      write_address_ff, write_address_in;
   logic             image_ok_ff, image_ok_in;
   logic             write_pending_ff, write_pending_in;
   logic [15:0]      page_sum_ff, page_sum_in;
   logic [IDX_W-1:0] word_cnt_ff, word_cnt_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   fpfr_pkg::kind_type  rsp_kind_ff, rsp_kind_in;
   logic [7:0]          rsp_exp_ff, rsp_exp_in;
   logic [7:0]          rsp_rcv_ff, rsp_rcv_in;
   logic [15:0]         rsp_pc_ff, rsp_pc_in;
   logic [15:0]         rsp_sum_ff, rsp_sum_in;
   logic [31:0]         rsp_addr_ff, rsp_addr_in;
   logic [63:0]         rsp_word_ff, rsp_word_in;
   logic                rsp_last_ff, rsp_last_in;

   // decode of the captured word
   logic [10:0]         byte_total;
   logic [15:0]         new_sum;
   logic [7:0]          host_code;
   logic                is_host, is_data, is_done;
   logic                hit_enter, hit_addr, hit_reset, hit_jump;
   logic                data_match, page_end, word_last, out_free;
   logic                first_valid;
   fpfr_pkg::kind_type  first_kind;
   logic [7:0]          first_exp, first_rcv;
   logic [15:0]         first_pc;
   logic [31:0]         first_addr;
   logic [63:0]         first_word;
   logic [63:0]         ram_rdata;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         hold_cmd_ff     <= req_cmd;
         hold_id_ff      <= req_frame_id;
         hold_payload_ff <= req_payload;
         hold_wok_ff     <= req_write_ok;
      end
   end

   always_comb begin
      byte_total = 11'd0;
      for (int b = 0; b < 8; b++) begin
         byte_total = byte_total + 11'(hold_payload_ff[8*b +: 8]);
      end
   end

   assign new_sum    = running_sum_ff + 16'(byte_total);
   assign host_code  = hold_id_ff[7:0];
   assign is_done    = hold_cmd_ff == fpfr_pkg::CMD_WRITE_DONE;
   assign is_host    = hold_cmd_ff == fpfr_pkg::CMD_FRAME
                       && hold_id_ff[10:8] == fpfr_pkg::ID_CLASS_HOST;
   assign is_data    = hold_cmd_ff == fpfr_pkg::CMD_FRAME
                       && hold_id_ff[10:8] == fpfr_pkg::ID_CLASS_DATA;
   // first matching host id wins
   assign hit_enter  = is_host && host_code == cfg.enter_cmd_id;
   assign hit_addr   = is_host && !hit_enter && host_code == cfg.address_cmd_id;
   assign hit_reset  = is_host && !hit_enter && !hit_addr && host_code == cfg.reset_cmd_id;
   assign hit_jump   = is_host && !hit_enter && !hit_addr && !hit_reset
                       && host_code == cfg.jump_cmd_id;
   assign data_match = is_data && host_code == 8'(next_index_ff);
   assign page_end   = data_match && next_index_ff == IDX_LAST;
   assign word_last  = word_cnt_ff == IDX_LAST;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   assign status.out_free  = out_free;
   assign status.page_end  = page_end;
   assign status.word_last = word_last;

   // first result of the word, if any
   always_comb begin
      first_valid = 1'b0;
      first_kind  = fpfr_pkg::KIND_WRONG_INDEX;
      first_exp   = 8'd0;
      first_rcv   = 8'd0;
      first_pc    = 16'd0;
      first_addr  = 32'd0;
      first_word  = 64'd0;
      if (is_done) begin
         if (write_pending_ff) begin
            first_valid = 1'b1;
            first_pc    = pages_done_ff;
            if (hold_wok_ff) begin
               first_kind = fpfr_pkg::KIND_WRITE_OK;
               first_addr = write_address_ff;
            end else begin
               first_kind = fpfr_pkg::KIND_WRITE_ERROR;
            end
         end
      end else if (hit_enter) begin
         first_valid = 1'b1;
         first_kind  = fpfr_pkg::KIND_ERASE;
      end else if (hit_reset) begin
         first_valid = 1'b1;
         first_kind  = fpfr_pkg::KIND_RESET_ACK;
         first_pc    = pages_done_ff;
      end else if (hit_jump) begin
         first_valid = 1'b1;
         if (image_ok_ff) begin
            first_kind = fpfr_pkg::KIND_JUMP;
            first_addr = start_address_ff;
         end else begin
            first_kind = fpfr_pkg::KIND_REFUSED;
         end
      end else if (is_data) begin
         if (!data_match) begin
            first_valid = 1'b1;
            first_kind  = fpfr_pkg::KIND_WRONG_INDEX;
            first_exp   = 8'(next_index_ff);
            first_rcv   = host_code;
         end else if (cfg.echo_enable) begin
            first_valid = 1'b1;
            first_kind  = fpfr_pkg::KIND_ECHO;
            first_exp   = 8'(next_index_ff);
            first_rcv   = 8'(next_index_ff);
            first_word  = hold_payload_ff;
         end
      end
   end

   // loader state update on execute
   always_comb begin
      next_index_in    = next_index_ff;
      running_sum_in   = running_sum_ff;
      pages_done_in    = pages_done_ff;
      start_address_in = start_address_ff;
      write_address_in = write_address_ff;
      image_ok_in      = image_ok_ff;
      write_pending_in = write_pending_ff;
      page_sum_in      = page_sum_ff;
      if (cmd.execute) begin
         if (is_done) begin
            if (write_pending_ff) begin
               write_pending_in = 1'b0;
               if (hold_wok_ff) begin
                  pages_done_in    = pages_done_ff + 16'd1;
                  image_ok_in      = 1'b1;
                  write_address_in = write_address_ff + ADDR_STEP;
               end
            end
         end else if (hit_enter) begin
            image_ok_in = 1'b0;
         end else if (hit_addr) begin
            start_address_in = hold_payload_ff[31:0];
            write_address_in = hold_payload_ff[31:0];
         end else if (hit_reset) begin
            running_sum_in = 16'd0;
            next_index_in  = '0;
         end else if (is_data) begin
            image_ok_in = 1'b0;
            if (data_match) begin
               if (page_end) begin
                  next_index_in    = '0;
                  running_sum_in   = 16'd0;
                  page_sum_in      = new_sum;
                  write_pending_in = 1'b1;
               end else begin
                  next_index_in  = next_index_ff + IDX_W'(1);
                  running_sum_in = new_sum;
               end
            end
         end
      end
   end

   always_comb begin
      word_cnt_in = word_cnt_ff;
      if (cmd.load_done) begin
         word_cnt_in = '0;
      end else if (cmd.load_word && !word_last) begin
         word_cnt_in = word_cnt_ff + IDX_W'(1);
      end
   end

   // output register, loaded only when free
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_exp_in   = rsp_exp_ff;
      rsp_rcv_in   = rsp_rcv_ff;
      rsp_pc_in    = rsp_pc_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.execute && first_valid) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = first_kind;
         rsp_exp_in   = first_exp;
         rsp_rcv_in   = first_rcv;
         rsp_pc_in    = first_pc;
         rsp_sum_in   = 16'd0;
         rsp_addr_in  = first_addr;
         rsp_word_in  = first_word;
         rsp_last_in  = !page_end;
      end else if (cmd.load_done) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = fpfr_pkg::KIND_PAGE_DONE;
         rsp_exp_in   = 8'd0;
         rsp_rcv_in   = 8'd0;
         rsp_pc_in    = pages_done_ff;
         rsp_sum_in   = page_sum_ff;
         rsp_addr_in  = write_address_ff;
         rsp_word_in  = 64'd0;
         rsp_last_in  = 1'b0;
      end else if (cmd.load_word) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = fpfr_pkg::KIND_PAGE_WORD;
         rsp_exp_in   = 8'(word_cnt_ff);
         rsp_rcv_in   = 8'd0;
         rsp_pc_in    = 16'd0;
         rsp_sum_in   = 16'd0;
         rsp_addr_in  = write_address_ff;
         rsp_word_in  = ram_rdata;
         rsp_last_in  = word_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_index_ff    <= '0;
         running_sum_ff   <= 16'd0;
         pages_done_ff    <= 16'd0;
         start_address_ff <= fpfr_pkg::ADDR_RESET;
         write_address_ff <= fpfr_pkg::ADDR_RESET;
         image_ok_ff      <= 1'b0;
         write_pending_ff <= 1'b0;
         word_cnt_ff      <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         next_index_ff    <= next_index_in;
         running_sum_ff   <= running_sum_in;
         pages_done_ff    <= pages_done_in;
         start_address_ff <= start_address_in;
         write_address_ff <= write_address_in;
         image_ok_ff      <= image_ok_in;
         write_pending_ff <= write_pending_in;
         word_cnt_ff      <= word_cnt_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_sum_ff <= page_sum_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_exp_ff  <= rsp_exp_in;
      rsp_rcv_ff  <= rsp_rcv_in;
      rsp_pc_ff   <= rsp_pc_in;
      rsp_sum_ff  <= rsp_sum_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_word_ff <= rsp_word_in;
      rsp_last_ff <= rsp_last_in;
   end

   fpfr_ram #(
      .WIDTH (64),
      .DEPTH (PAGE_WORDS)
   ) u_page_ram (
      .clock (clock),
      .we    (cmd.execute && data_match),
      .waddr (next_index_ff),
      .wdata (hold_payload_ff),
      .re    (cmd.rd_en),
      .raddr (word_cnt_ff),
      .rdata (ram_rdata)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_exp_index  = rsp_exp_ff;
   assign rsp_rcv_index  = rsp_rcv_ff;
   assign rsp_page_count = rsp_pc_ff;
   assign rsp_byte_sum   = rsp_sum_ff;
   assign rsp_address    = rsp_addr_ff;
   assign rsp_word       = rsp_word_ff;
   assign rsp_last       = rsp_last_ff;

`ifndef SYNTHESIS
   ap_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready
      |-> !(cmd.load_done || cmd.load_word || (cmd.execute && first_valid)))
      else $error("output register loaded while stalled");

   ap_page_sets_pending: assert property (@(posedge clock) disable iff (reset)
      cmd.execute && page_end |=> write_pending_ff && next_index_ff == '0)
      else $error("page completion did not arm the write");

   ap_last_word_flag: assert property (@(posedge clock) disable iff (reset)
      cmd.load_word && word_last |=> rsp_valid_ff && rsp_last_ff)
      else $error("final page word not marked last");

   ap_done_not_last: assert property (@(posedge clock) disable iff (reset)
      cmd.load_done |=> rsp_valid_ff && !rsp_last_ff
      && rsp_kind_ff == fpfr_pkg::KIND_PAGE_DONE)
      else $error("page done marked last");
`endif

endmodule

`default_nettype wire

// File: hdl/firmware_page_frame_receiver.sv
// top level of the firmware page frame receiver
`timescale 1ns / 1ps
`default_nettype none

// Receives bus frames and flash-write completions one word at a time. A word
// is captured and then executed as soon as the output register is free,
// whether it is a host frame, a data frame or a completion. The data frame
// that completes a page also reports the page and reads all PAGE_WORDS words
// back from the page memory through its registered read port, one read and
// one word load per word, so the block takes the next word only after that
// readout ends. The output register lets a new word in while a result still
// waits. The page memory needs no clearing after reset. Configuration
// registers lie at byte addresses 0x00, 0x04, 0x08, 0x0c (enter, address,
// reset and jump ids) and 0x10 (echo enable).
module firmware_page_frame_receiver #(
   parameter int PAGE_WORDS = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   fpfr_req_if.sink                             req_chan,
   fpfr_rsp_if.source                           rsp_chan,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [fpfr_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                     pwdata,
   output logic      [31:0]                     prdata,
   output logic                                 pready
);

   fpfr_pkg::cfg_type       cfg;
   fpfr_pkg::dp_cmd_type    dp_cmd;
   fpfr_pkg::dp_status_type dp_status;
   logic                    req_ready;

   fpfr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   fpfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   assign req_chan.ready = req_ready;

   fpfr_dp #(
      .PAGE_WORDS (PAGE_WORDS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (dp_cmd),
      .status         (dp_status),
      .cfg            (cfg),
      .req_cmd        (req_chan.cmd),
      .req_frame_id   (req_chan.frame_id),
      .req_payload    (req_chan.payload),
      .req_write_ok   (req_chan.write_ok),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_kind       (rsp_chan.kind),
      .rsp_exp_index  (rsp_chan.exp_index),
      .rsp_rcv_index  (rsp_chan.rcv_index),
      .rsp_page_count (rsp_chan.page_count),
      .rsp_byte_sum   (rsp_chan.byte_sum),
      .rsp_address    (rsp_chan.address),
      .rsp_word       (rsp_chan.word),
      .rsp_last       (rsp_chan.last)
   );

endmodule

`default_nettype wire
